### rtl/rtsa_pkg.sv
// Package: shared constants, codes and structs of the RadioText segment assembler.
`default_nettype none
package rtsa_pkg;

  localparam int TEXT_LEN = 64;
  localparam int MASK_W   = 64;
  localparam int POS_W    = 6;
  localparam int WORDS    = (TEXT_LEN + 3) / 4;
  localparam int ROWS     = WORDS;
  localparam int ROW_W    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int WIDX_W   = 4;
  localparam int LANES    = 4;

  localparam logic [7:0]        CR_CHAR = 8'd13;
  localparam logic [MASK_W-1:0] FULL_A  = {MASK_W{1'b1}} >> (MASK_W - TEXT_LEN);
  localparam logic [MASK_W-1:0] FULL_B  = 64'h0000_0000_FFFF_FFFF;

  localparam logic [1:0] KIND_CLEARED = 2'd0;
  localparam logic [1:0] KIND_PARTIAL = 2'd1;
  localparam logic [1:0] KIND_WORD    = 2'd2;

  localparam logic [2:0] COUNT_A = 3'd4;
  localparam logic [2:0] COUNT_B = 3'd2;

  typedef struct packed {
    logic       version_a;
    logic       ab_flag;
    logic [3:0] segment_address;
    logic [7:0] char_a;
    logic [7:0] char_b;
    logic [7:0] char_c;
    logic [7:0] char_d;
  } item_t;

  typedef struct packed {
    logic              load;
    logic              set_done;
    logic              rd_en;
    logic [WIDX_W-1:0] word;
    logic [1:0]        kind;
  } cmd_t;

  typedef struct packed {
    logic ab_change;
    logic start;
  } status_t;

  typedef struct packed {
    logic [POS_W-1:0]  write_address;
    logic [2:0]        write_count;
    logic [WIDX_W-1:0] word_index;
    logic [31:0]       text_word;
  } result_t;

endpackage
`default_nettype wire

### rtl/rtsa_in_if.sv
// Interface: input channel carrying one decoded RadioText group.
`default_nettype none
interface rtsa_in_if;
  logic       valid;
  logic       ready;
  logic       version_a;
  logic       ab_flag;
  logic [3:0] segment_address;
  logic [7:0] char_a;
  logic [7:0] char_b;
  logic [7:0] char_c;
  logic [7:0] char_d;

  modport source (output valid, version_a, ab_flag, segment_address,
                  char_a, char_b, char_c, char_d, input ready);
  modport sink (input valid, version_a, ab_flag, segment_address,
                char_a, char_b, char_c, char_d, output ready);
endinterface
`default_nettype wire

### rtl/rtsa_out_if.sv
// Interface: result channel of the RadioText segment assembler.
`default_nettype none
interface rtsa_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [5:0]  write_address;
  logic [2:0]  write_count;
  logic [3:0]  word_index;
  logic [31:0] text_word;
  logic        last;

  modport source (output valid, kind, write_address, write_count, word_index,
                  text_word, last, input ready);
  modport sink (input valid, kind, write_address, write_count, word_index,
                text_word, last, output ready);
endinterface
`default_nettype wire

### rtl/radiotext_segment_assembler.sv
// Top level: RadioText group 2A/2B segment assembler.
//
//  channel  dir  handshake    payload
//  grp      in   valid/ready  version_a, ab_flag, segment_address, char_a..char_d
//  res      out  valid/ready  kind, write_address, write_count, word_index,
//                             text_word, last
//
// One group at a time: accept, then the reports in order (cleared, only when
// the A/B flag changes, then partial update). On completion the readout adds
// a RAM read, then a present step, per word, for 16 words. Each report holds
// until res.ready.
// Synchronous active-high reset clears the masks, flag and state; the store
// needs no clearing pass since unset positions read as zero.
`default_nettype none
module radiotext_segment_assembler (
  input wire logic  clk,
  input wire logic  rst,
  rtsa_in_if.sink   grp,
  rtsa_out_if.source res
);

  rtsa_pkg::item_t   item;
  rtsa_pkg::cmd_t    cmd;
  rtsa_pkg::status_t status;
  rtsa_pkg::result_t result;

  assign item.version_a       = grp.version_a;
  assign item.ab_flag         = grp.ab_flag;
  assign item.segment_address = grp.segment_address;
  assign item.char_a          = grp.char_a;
  assign item.char_b          = grp.char_b;
  assign item.char_c          = grp.char_c;
  assign item.char_d          = grp.char_d;

  rtsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .grp_valid (grp.valid),
    .grp_ready (grp.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_last  (res.last),
    .status    (status),
    .cmd       (cmd)
  );

  rtsa_datapath u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

  assign res.kind          = cmd.kind;
  assign res.write_address = result.write_address;
  assign res.write_count   = result.write_count;
  assign res.word_index    = result.word_index;
  assign res.text_word     = result.text_word;

endmodule
`default_nettype wire

### rtl/rtsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rtsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/rtsa_datapath.sv
// Datapath: byte-lane text store, set and CR masks, completion test, result payload.
`default_nettype none
module rtsa_datapath (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rtsa_pkg::item_t   item,
  input  wire rtsa_pkg::cmd_t    cmd,
  output rtsa_pkg::status_t      status,
  output rtsa_pkg::result_t      result
);

  logic [rtsa_pkg::MASK_W-1:0] mask;
  logic [rtsa_pkg::MASK_W-1:0] mask_next;
  logic [rtsa_pkg::MASK_W-1:0] cr;
  logic [rtsa_pkg::MASK_W-1:0] cr_next;
  logic                        current_ab;
  logic                        completed;
  logic                        ver_a;
  logic [3:0]                  seg;

  logic [rtsa_pkg::LANES-1:0]  lane_we;
  logic [7:0]                  lane_wdata [rtsa_pkg::LANES];
  logic [rtsa_pkg::POS_W-1:0]  lane_pos [rtsa_pkg::LANES];
  logic [7:0]                  lane_rdata [rtsa_pkg::LANES];
  logic [3:0]                  row_in;
  logic                        ab_change;

  logic [rtsa_pkg::MASK_W-1:0] run;
  logic                        done;
  logic [31:0]                 word_bytes;

  assign ab_change = item.ab_flag != current_ab;
  assign row_in    = item.version_a ? item.segment_address
                                    : {1'b0, item.segment_address[3:1]};

  always_comb begin
    mask_next = ab_change ? '0 : mask;
    cr_next   = ab_change ? '0 : cr;
    for (int l = 0; l < rtsa_pkg::LANES; l++) begin
      lane_pos[l] = {row_in, 2'(l)};
      if (item.version_a) begin
        case (l)
          0:       lane_wdata[l] = item.char_a;
          1:       lane_wdata[l] = item.char_b;
          2:       lane_wdata[l] = item.char_c;
          default: lane_wdata[l] = item.char_d;
        endcase
      end else begin
        lane_wdata[l] = (l % 2 == 1) ? item.char_d : item.char_c;
      end
      lane_we[l] = cmd.load
                   && (item.version_a || ((l / 2 == 1) == item.segment_address[0]))
                   && ({1'b0, lane_pos[l]} < (rtsa_pkg::POS_W + 1)'(rtsa_pkg::TEXT_LEN));
      if (lane_we[l]) begin
        mask_next[lane_pos[l]] = 1'b1;
        cr_next[lane_pos[l]]   = lane_wdata[l] == rtsa_pkg::CR_CHAR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask       <= '0;
      cr         <= '0;
      current_ab <= 1'b0;
      completed  <= 1'b0;
    end else begin
      if (cmd.load) begin
        mask       <= mask_next;
        cr         <= cr_next;
        current_ab <= item.ab_flag;
        if (ab_change) begin
          completed <= 1'b0;
        end
      end else if (cmd.set_done) begin
        completed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ver_a <= item.version_a;
      seg   <= item.segment_address;
    end
  end

  for (genvar g = 0; g < rtsa_pkg::LANES; g++) begin : g_lane
    rtsa_ram #(
      .WIDTH (8),
      .DEPTH (rtsa_pkg::ROWS)
    ) u_ram (
      .clk   (clk),
      .we    (lane_we[g]),
      .waddr (row_in[rtsa_pkg::ROW_W-1:0]),
      .wdata (lane_wdata[g]),
      .re    (cmd.rd_en),
      .raddr (cmd.word[rtsa_pkg::ROW_W-1:0]),
      .rdata (lane_rdata[g])
    );
  end

  // gapless run of set positions starting at position 0
  assign run  = mask & ~(mask + rtsa_pkg::MASK_W'(1));
  assign done = (ver_a ? (mask == rtsa_pkg::FULL_A) : (mask == rtsa_pkg::FULL_B))
                || (|(run & cr));

  assign status.ab_change = ab_change;
  assign status.start     = !completed && done;

  always_comb begin
    for (int l = 0; l < rtsa_pkg::LANES; l++) begin
      word_bytes[8*l +: 8] = mask[{cmd.word, 2'(l)}] ? lane_rdata[l] : 8'd0;
    end
  end

  always_comb begin
    result = '0;
    case (cmd.kind)
      rtsa_pkg::KIND_PARTIAL: begin
        result.write_address = ver_a ? {seg, 2'b00} : {1'b0, seg, 1'b0};
        result.write_count   = ver_a ? rtsa_pkg::COUNT_A : rtsa_pkg::COUNT_B;
      end
      rtsa_pkg::KIND_WORD: begin
        result.word_index = cmd.word;
        result.text_word  = word_bytes;
      end
      default: result = '0;
    endcase
  end

endmodule
`default_nettype wire

### rtl/rtsa_ctrl.sv
// Controller: sequences accept, cleared and partial reports, and the text readout.
`default_nettype none
module rtsa_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              grp_valid,
  output logic                   grp_ready,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output logic                   res_last,
  input  wire rtsa_pkg::status_t status,
  output rtsa_pkg::cmd_t         cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CLR  = 3'd1;
  localparam logic [2:0] S_PART = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_WORD = 3'd4;

  localparam logic [rtsa_pkg::WIDX_W-1:0] LAST_WORD =
    rtsa_pkg::WIDX_W'(rtsa_pkg::WORDS - 1);

  logic [2:0]                  state;
  logic [2:0]                  state_next;
  logic [rtsa_pkg::WIDX_W-1:0] word;
  logic [rtsa_pkg::WIDX_W-1:0] word_next;
  logic                        take;

  assign grp_ready = (state == S_IDLE) && !rst;
  assign res_valid = (state == S_CLR) || (state == S_PART) || (state == S_WORD);
  assign take      = res_valid && res_ready;

  always_comb begin
    state_next   = state;
    word_next    = word;
    res_last     = 1'b0;
    cmd          = '0;
    cmd.word     = word;
    cmd.kind     = rtsa_pkg::KIND_CLEARED;
    unique case (state)
      S_IDLE: begin
        cmd.load = grp_valid && grp_ready;
        if (cmd.load) begin
          state_next = status.ab_change ? S_CLR : S_PART;
        end
      end
      S_CLR: begin
        cmd.kind = rtsa_pkg::KIND_CLEARED;
        if (res_ready) begin
          state_next = S_PART;
        end
      end
      S_PART: begin
        cmd.kind = rtsa_pkg::KIND_PARTIAL;
        res_last = !status.start;
        if (res_ready) begin
          cmd.set_done = status.start;
          word_next    = '0;
          state_next   = status.start ? S_RD : S_IDLE;
        end
      end
      S_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = S_WORD;
      end
      S_WORD: begin
        cmd.kind = rtsa_pkg::KIND_WORD;
        res_last = word == LAST_WORD;
        if (res_ready) begin
          word_next  = word + 1'b1;
          state_next = (word == LAST_WORD) ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      word  <= '0;
    end else begin
      state <= state_next;
      word  <= word_next;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(grp_ready && res_valid))
    else $error("input accepted while a result is pending");

  a_accept_reports: assert property (@(posedge clk) disable iff (rst)
    (grp_valid && grp_ready) |=> res_valid)
    else $error("accepted group not reported in the next cycle");

  a_readout_starts: assert property (@(posedge clk) disable iff (rst)
    (state == S_PART && take && status.start) |=> (state == S_RD && word == '0))
    else $error("readout did not start after completion");

  a_word_bound: assert property (@(posedge clk) disable iff (rst)
    word <= LAST_WORD)
    else $error("word counter out of range");

endmodule
`default_nettype wire
